### hdl/aging_page_replacement_assert.svh
// ----------------------------------------------------------------------------
// Aging page replacement assertion macros
// Concurrent assertion wrappers clocked on clk with reset disable.
// ----------------------------------------------------------------------------
`ifndef AGING_PAGE_REPLACEMENT_ASSERT_SVH
`define AGING_PAGE_REPLACEMENT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define APR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define APR_ASSERT_IMPL(label, ante, cons, msg)
`define APR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### hdl/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and fixed field layout for the aging page replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apr_pkg;

    localparam int PAGE_W      = 16;
    localparam int OUT_IDX_W   = 6;
    localparam int COUNT_W     = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 88;

    // result item layout inside m_tdata
    localparam int OUT_HIT_LSB   = 0;
    localparam int OUT_IDX_LSB   = 1;
    localparam int OUT_EVICT_LSB = 7;
    localparam int OUT_HITS_LSB  = 23;
    localparam int OUT_MISS_LSB  = 55;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_AGE  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic clear;
        logic en;
    } scan_ctl_t;

endpackage

`default_nettype wire

### hdl/apr_frame_store.sv
// ----------------------------------------------------------------------------
// apr_frame_store
// Frame table memory holding page and age per frame; one read, one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apr_frame_store #(
    parameter int FRAME_COUNT = 16,
    parameter int WORD_W      = 24,
    localparam int IDX_W      = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output logic      [WORD_W-1:0]    rd_data,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire logic [WORD_W-1:0]    wr_data
);

    logic [WORD_W-1:0]      mem [FRAME_COUNT];
    logic [WORD_W-1:0]      rd_word_reg;
    logic                   rd_vld_reg;
    logic [FRAME_COUNT-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // a frame never written reads as empty with a cleared counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

### hdl/apr_scan_unit.sv
// ----------------------------------------------------------------------------
// apr_scan_unit
// Shared compare unit: page match and minimum age search, one frame a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apr_scan_unit #(
    parameter int FRAME_COUNT  = 16,
    parameter int COUNTER_BITS = 8,
    localparam int IDX_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire apr_pkg::scan_ctl_t         ctl,
    input  wire logic [IDX_W-1:0]           idx,
    input  wire logic [apr_pkg::PAGE_W-1:0] search_page,
    input  wire logic [apr_pkg::PAGE_W-1:0] frame_page,
    input  wire logic [COUNTER_BITS-1:0]    frame_age,
    output logic                            found,
    output logic      [IDX_W-1:0]           match_slot,
    output logic      [IDX_W-1:0]           best_slot,
    output logic      [apr_pkg::PAGE_W-1:0] best_page
);

    logic                        found_reg;
    logic                        first_reg;
    logic [IDX_W-1:0]            match_slot_reg;
    logic [IDX_W-1:0]            best_slot_reg;
    logic [COUNTER_BITS-1:0]     best_age_reg;
    logic [apr_pkg::PAGE_W-1:0]  best_page_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (ctl.en)
        begin
            first_reg <= 1'b0;
            if (!found_reg && (frame_page == search_page))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            // keep the first matching frame
            if (!found_reg && (frame_page == search_page))
            begin
                match_slot_reg <= idx;
            end
            // strict compare keeps the lowest index on ties
            if (first_reg || (frame_age < best_age_reg))
            begin
                best_age_reg  <= frame_age;
                best_slot_reg <= idx;
                best_page_reg <= frame_page;
            end
        end
    end

    assign found      = found_reg;
    assign match_slot = match_slot_reg;
    assign best_slot  = best_slot_reg;
    assign best_page  = best_page_reg;

endmodule

`default_nettype wire

### hdl/aging_page_replacement.sv
// ----------------------------------------------------------------------------
// aging_page_replacement
// Aging page replacement over FRAME_COUNT frames with COUNTER_BITS age counters.
// ----------------------------------------------------------------------------
// Each input item is one page reference. The frame table is walked twice
// through the single read port of the frame store: a lookup pass that finds a
// match and the oldest frame, then an aging pass that rewrites every frame.
// A reference to page zero changes nothing. The block takes a new item
// only while idle, and a finished result waits in the output register while
// the next item is worked on. Frames start empty after reset with no
// clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "aging_page_replacement_assert.svh"

module aging_page_replacement #(
    parameter int FRAME_COUNT  = 16,
    parameter int COUNTER_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // page_number[15:0]
    input  wire logic [apr_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // was_hit[0], frame_index[6:1], evicted_page[22:7], hits_so_far[54:23],
    // misses_so_far[86:55], zero pad[87]
    output logic      [apr_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int IDX_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
    localparam int PAGE_W = apr_pkg::PAGE_W;
    localparam int WORD_W = PAGE_W + COUNTER_BITS;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_COUNT);

    apr_pkg::state_t state_reg, state_next;

    logic [PAGE_W-1:0]             page_reg;
    logic [CNT_W-1:0]              rd_cnt_reg;
    logic                          pend_reg;
    logic [IDX_W-1:0]              pend_idx_reg;
    logic                          hit_reg;
    logic [IDX_W-1:0]              slot_reg;
    logic [PAGE_W-1:0]             evicted_reg;
    logic [apr_pkg::COUNT_W-1:0]   hit_count_reg;
    logic [apr_pkg::COUNT_W-1:0]   miss_count_reg;
    logic                          m_tvalid_reg;
    logic [apr_pkg::OUT_TDATA_W-1:0] m_data_reg;

    logic                          accept;
    logic                          issue;
    logic                          pass_end;
    logic                          out_free;

    logic                          st_rd_en;
    logic [WORD_W-1:0]             st_rd_data;
    logic                          st_wr_en;
    logic [WORD_W-1:0]             st_wr_data;
    logic [PAGE_W-1:0]             rd_page;
    logic [COUNTER_BITS-1:0]       rd_age;

    apr_pkg::scan_ctl_t            scan_ctl;
    logic                          sc_found;
    logic [IDX_W-1:0]              sc_match_slot;
    logic [IDX_W-1:0]              sc_best_slot;
    logic [PAGE_W-1:0]             sc_best_page;

    logic                          is_slot;
    logic                          replace;
    logic [PAGE_W-1:0]             wb_page;
    logic [COUNTER_BITS-1:0]       wb_base;
    logic [COUNTER_BITS-1:0]       wb_age;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == apr_pkg::S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // issue one frame read per cycle during each pass
    assign issue    = ((state_reg == apr_pkg::S_SCAN) || (state_reg == apr_pkg::S_AGE))
                      && (rd_cnt_reg != LAST_CNT);
    assign pass_end = (rd_cnt_reg == LAST_CNT) && !pend_reg;
    assign st_rd_en = issue;

    assign rd_page = st_rd_data[WORD_W-1:COUNTER_BITS];
    assign rd_age  = st_rd_data[COUNTER_BITS-1:0];

    assign scan_ctl.clear = accept;
    assign scan_ctl.en    = pend_reg && (state_reg == apr_pkg::S_SCAN);

    // aging write-back: shift right, set the top bit of the referenced frame, and on a miss load the new page into it
    assign is_slot    = (pend_idx_reg == slot_reg);
    assign replace    = is_slot && !hit_reg;
    assign wb_page    = replace ? page_reg : rd_page;
    assign wb_base    = replace ? '0 : rd_age;
    assign wb_age     = {is_slot, wb_base[COUNTER_BITS-1:1]};
    assign st_wr_en   = pend_reg && (state_reg == apr_pkg::S_AGE);
    assign st_wr_data = {wb_page, wb_age};

    apr_frame_store #(
        .FRAME_COUNT (FRAME_COUNT),
        .WORD_W      (WORD_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (st_rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (pend_idx_reg),
        .wr_data (st_wr_data)
    );

    apr_scan_unit #(
        .FRAME_COUNT  (FRAME_COUNT),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .idx         (pend_idx_reg),
        .search_page (page_reg),
        .frame_page  (rd_page),
        .frame_age   (rd_age),
        .found       (sc_found),
        .match_slot  (sc_match_slot),
        .best_slot   (sc_best_slot),
        .best_page   (sc_best_page)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            apr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_tdata[PAGE_W-1:0] == '0) ? apr_pkg::S_DONE
                                                             : apr_pkg::S_SCAN;
                end
            end
            apr_pkg::S_SCAN:
            begin
                if (pass_end)
                begin
                    state_next = apr_pkg::S_AGE;
                end
            end
            apr_pkg::S_AGE:
            begin
                if (pass_end)
                begin
                    state_next = apr_pkg::S_DONE;
                end
            end
            apr_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = apr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = apr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= apr_pkg::S_IDLE;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            else if (pass_end)
            begin
                rd_cnt_reg <= '0;
            end
            if ((state_reg == apr_pkg::S_SCAN) && pass_end)
            begin
                if (sc_found)
                begin
                    if (hit_count_reg != '1)
                    begin
                        hit_count_reg <= hit_count_reg + 1'b1;
                    end
                end
                else if (miss_count_reg != '1)
                begin
                    miss_count_reg <= miss_count_reg + 1'b1;
                end
            end
            // a new result replaces one that leaves in the same cycle
            if ((state_reg == apr_pkg::S_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        end
        if (accept)
        begin
            page_reg    <= s_tdata[PAGE_W-1:0];
            // page zero leaves these as its result
            hit_reg     <= 1'b0;
            slot_reg    <= '0;
            evicted_reg <= '0;
        end
        if ((state_reg == apr_pkg::S_SCAN) && pass_end)
        begin
            hit_reg     <= sc_found;
            slot_reg    <= sc_found ? sc_match_slot : sc_best_slot;
            evicted_reg <= sc_found ? '0 : sc_best_page;
        end
        if ((state_reg == apr_pkg::S_DONE) && out_free)
        begin
            m_data_reg <= {1'b0, miss_count_reg, hit_count_reg, evicted_reg,
                           apr_pkg::OUT_IDX_W'(slot_reg), hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    `APR_ASSERT_IMPL(a_scan_in_scan, scan_ctl.en, state_reg == apr_pkg::S_SCAN, "compare outside lookup pass")
    `APR_ASSERT_IMPL(a_write_in_age, st_wr_en, state_reg == apr_pkg::S_AGE, "frame write outside aging pass")
    `APR_ASSERT_IMPL(a_hit_no_evict, m_tvalid_reg && m_data_reg[apr_pkg::OUT_HIT_LSB], m_data_reg[apr_pkg::OUT_HITS_LSB-1:apr_pkg::OUT_EVICT_LSB] == '0, "hit reports an eviction")
    `APR_ASSERT_NEXT(a_accept_busy, accept, state_reg != apr_pkg::S_IDLE, "accepted item did not start")

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the aging page replacement block. A queue of page
// references, directed first and then random with a shifting working set,
// feeds a clocked driver. A clocked monitor predicts each accepted reference
// and compares every result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

    localparam int FRAMES       = 16;
    localparam int AGE_W        = 8;
    localparam int RANDOM_REFS  = 1000;
    localparam int SETTLE_TICKS = 100;

    typedef struct packed {
        logic                         hit;
        logic [apr_pkg::OUT_IDX_W-1:0] frame;
        logic [apr_pkg::PAGE_W-1:0]   evicted;
        logic [apr_pkg::COUNT_W-1:0]  hits;
        logic [apr_pkg::COUNT_W-1:0]  misses;
    } lookup_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [apr_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [apr_pkg::OUT_TDATA_W-1:0] m_tdata;

    // shadow of the frame table
    logic [apr_pkg::PAGE_W-1:0]  resident_page [FRAMES];
    logic [AGE_W-1:0]            page_age [FRAMES];
    logic [apr_pkg::COUNT_W-1:0] hit_total;
    logic [apr_pkg::COUNT_W-1:0] miss_total;

    logic [apr_pkg::PAGE_W-1:0] page_refs_pending [$];
    lookup_result_t             expected_lookups [$];
    int                         total_refs;
    int                         refs_taken;
    int                         failures;
    logic                       ref_taken;
    int                         tx_idle_pct;
    int                         rx_idle_pct;

    aging_page_replacement #(
        .FRAME_COUNT  (FRAMES),
        .COUNTER_BITS (AGE_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic lookup_result_t predict_reference(input logic [apr_pkg::PAGE_W-1:0] page);
        lookup_result_t res;
        int             slot;
        logic           found;
        logic [AGE_W-1:0] oldest;
        slot  = 0;
        found = 1'b0;
        res   = '0;
        if (page != '0)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                if (!found && resident_page[i] == page)
                begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                if (hit_total != '1)
                    hit_total = hit_total + 1;
            end
            else
            begin
                // lowest index wins on equal ages
                oldest = page_age[0];
                for (int i = 1; i < FRAMES; i++)
                begin
                    if (page_age[i] < oldest)
                    begin
                        oldest = page_age[i];
                        slot   = i;
                    end
                end
                if (miss_total != '1)
                    miss_total = miss_total + 1;
                res.evicted         = resident_page[slot];
                resident_page[slot] = page;
                page_age[slot]      = '0;
            end
            for (int i = 0; i < FRAMES; i++)
            begin
                page_age[i] = page_age[i] >> 1;
                if (i == slot)
                    page_age[i][AGE_W-1] = 1'b1;
            end
        end
        res.hit    = found;
        res.frame  = slot[apr_pkg::OUT_IDX_W-1:0];
        res.hits   = hit_total;
        res.misses = miss_total;
        return res;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
            failures++;
        end
    endtask

    // driver: hold an offered item until taken, idle at random otherwise
    always @(negedge clk)
    begin
        case (refs_taken * 3 / (total_refs == 0 ? 1 : total_refs))
            0:       begin tx_idle_pct = 23; rx_idle_pct = 72; end
            1:       begin tx_idle_pct = 72; rx_idle_pct = 23; end
            default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        endcase
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
            if (s_tvalid && !ref_taken)
                s_tvalid <= 1'b1;
            else if (page_refs_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= page_refs_pending.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor: compare results first, then predict the newly taken item
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (!rst_n)
            ref_taken <= 1'b0;
        else
        begin
            ref_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (expected_lookups.size() == 0)
                begin
                    $display("%0t: unexpected result item %0h", $time, m_tdata);
                    failures++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    check_field("was_hit", want.hit, m_tdata[apr_pkg::OUT_HIT_LSB]);
                    check_field("frame_index", want.frame,
                                m_tdata[apr_pkg::OUT_IDX_LSB +: apr_pkg::OUT_IDX_W]);
                    check_field("evicted_page", want.evicted,
                                m_tdata[apr_pkg::OUT_EVICT_LSB +: apr_pkg::PAGE_W]);
                    check_field("hits_so_far", want.hits,
                                m_tdata[apr_pkg::OUT_HITS_LSB +: apr_pkg::COUNT_W]);
                    check_field("misses_so_far", want.misses,
                                m_tdata[apr_pkg::OUT_MISS_LSB +: apr_pkg::COUNT_W]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_lookups.push_back(predict_reference(s_tdata));
                refs_taken++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("aging_page_replacement: mismatch");
        $finish;
    end

    initial
    begin
        logic [apr_pkg::PAGE_W-1:0] working_set [$];
        logic [apr_pkg::PAGE_W-1:0] page;
        int                         live_refs;
        int                         pick;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        ref_taken  = 1'b0;
        refs_taken = 0;
        failures   = 0;
        total_refs = 0;
        hit_total  = '0;
        miss_total = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            resident_page[i] = '0;
            page_age[i]      = '0;
        end

        // page zero on an empty table, bit extremes, fill all frames but one
        page_refs_pending.push_back(16'h0000);
        page_refs_pending.push_back(16'hFFFF);
        page_refs_pending.push_back(16'h0001);
        page_refs_pending.push_back(16'h8000);
        page_refs_pending.push_back(16'h5555);
        page_refs_pending.push_back(16'hAAAA);
        for (int p = 2; p < 12; p++)
            page_refs_pending.push_back(p[15:0]);
        // hits with one frame still free, then a fill, an eviction and a hit on a new page
        page_refs_pending.push_back(16'hFFFF);
        page_refs_pending.push_back(16'h0001);
        page_refs_pending.push_back(16'h1234);
        page_refs_pending.push_back(16'h4321);
        page_refs_pending.push_back(16'h1234);
        page_refs_pending.push_back(16'h0000);
        page_refs_pending.push_back(16'h5555);

        // random: mostly a working set of 12 to 24 pages, around the size of the table
        live_refs = 0;
        while (live_refs < RANDOM_REFS)
        begin
            if (live_refs % 150 == 0)
            begin
                working_set.delete();
                repeat ($urandom_range(24, 12))
                    working_set.push_back(16'($urandom_range(65535, 1)));
            end
            pick = $urandom_range(99);
            if (pick < 3)
                page = '0;
            else if (pick < 15)
                page = 16'($urandom_range(65535, 1));
            else
                page = working_set[$urandom_range(working_set.size() - 1)];
            page_refs_pending.push_back(page);
            if (page != '0)
                live_refs++;
        end
        total_refs = page_refs_pending.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (page_refs_pending.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (failures == 0)
            $display("aging_page_replacement: match");
        else
            $display("aging_page_replacement: mismatch");
        $finish;
    end

endmodule
